// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the supervisor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define PWSUP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// clocked check that also runs during reset
`define PWSUP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/pwsup_pkg.sv -----
// package: types and constants of the power watchdog supervisor
package pwsup_pkg;

    localparam int AdcBits   = 10;
    localparam int TickBits  = 18;
    localparam int MsBits    = 16;
    localparam int SecBits   = 8;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 16;
    localparam int InBits    = ((AdcBits + 4 + 7) / 8) * 8;
    localparam int OutBits   = 8;

    localparam logic [TickBits-1:0] TickMax   = {TickBits{1'b1}};
    localparam logic [TickBits-1:0] FastLenMs = TickBits'(1000);
    localparam int                  MsPerSec  = 1000;

    typedef enum logic [2:0] {
        PH_STARTUP   = 3'd0,
        PH_HANDSHAKE = 3'd1,
        PH_WINDOW    = 3'd2,
        PH_OFF       = 3'd3,
        PH_CHECK     = 3'd4,
        PH_SETTLE    = 3'd5,
        PH_ENCHECK   = 3'd6,
        PH_HOSTWAIT  = 3'd7
    } t_phase;

    typedef enum logic [CfgIdxBits-1:0] {
        REG_HS_TIMEOUT  = 3'd0,
        REG_OFF_HOLD    = 3'd1,
        REG_SETTLE      = 3'd2,
        REG_V_THRESHOLD = 3'd3,
        REG_V_TIMEOUT   = 3'd4,
        REG_WINDOW_SEC  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [MsBits-1:0]   hs_timeout;
        logic [MsBits-1:0]   off_hold;
        logic [MsBits-1:0]   settle;
        logic [AdcBits-1:0]  v_threshold;
        logic [MsBits-1:0]   v_timeout;
        logic [TickBits-1:0] window_ms;
    } t_cfg;

    typedef struct packed {
        logic                watchdog_level;
        logic [AdcBits-1:0]  voltage_sample;
        logic                button_edge;
        logic                host_power_good;
        logic                fast_request;
    } t_item;

    // packed msb first, so tdata bit 0 is supply_enable
    typedef struct packed {
        logic   fast_active;
        logic   phase_changed;
        t_phase phase_code;
        logic   io_disable;
        logic   watchdog_drive;
        logic   supply_enable;
    } t_result;

endpackage

// ----- rtl/core/pwsup_cfg.sv -----
// configuration register file of the supervisor
module pwsup_cfg import pwsup_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [CfgIdxBits-1:0]  i_index,
    input  logic [CfgDataBits-1:0] i_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hs_timeout  <= MsBits'(2000);
            r_cfg.off_hold    <= MsBits'(2000);
            r_cfg.settle      <= MsBits'(200);
            r_cfg.v_threshold <= AdcBits'(450);
            r_cfg.v_timeout   <= MsBits'(1000);
            r_cfg.window_ms   <= TickBits'(90 * MsPerSec);
        end else if (i_we) begin
            unique case (i_index)
                REG_HS_TIMEOUT:  r_cfg.hs_timeout  <= i_data[MsBits-1:0];
                REG_OFF_HOLD:    r_cfg.off_hold    <= i_data[MsBits-1:0];
                REG_SETTLE:      r_cfg.settle      <= i_data[MsBits-1:0];
                REG_V_THRESHOLD: r_cfg.v_threshold <= i_data[AdcBits-1:0];
                REG_V_TIMEOUT:   r_cfg.v_timeout   <= i_data[MsBits-1:0];
                REG_WINDOW_SEC:  r_cfg.window_ms   <=
                    TickBits'({{(TickBits-SecBits){1'b0}}, i_data[SecBits-1:0]} * MsPerSec);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/pwsup_core.sv -----
// phase state machine: one tick per accepted item
module pwsup_core import pwsup_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase              r_phase, n_phase;
    logic [TickBits-1:0] r_tick, n_tick;
    logic                r_last, n_last;
    logic                r_btn, n_btn;
    logic                r_fast, n_fast;
    logic                r_goen, n_goen;
    logic                r_sup, n_sup;
    logic                r_wd, n_wd;
    logic                n_io;

    logic [TickBits-1:0] tick_inc;
    logic [TickBits-1:0] win_len;
    logic                v_good;
    logic                v_late;
    logic                fell;

    assign tick_inc = (r_tick == TickMax) ? r_tick : r_tick + TickBits'(1);
    assign v_good   = i_item.voltage_sample >= i_cfg.v_threshold;
    assign v_late   = tick_inc > TickBits'(i_cfg.v_timeout);
    assign fell     = r_last & ~i_item.watchdog_level;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_last  = r_last;
        n_btn   = r_btn | i_item.button_edge;
        n_fast  = r_fast | i_item.fast_request;
        n_goen  = r_goen;
        n_sup   = r_sup;
        n_wd    = r_wd;
        win_len = n_fast ? FastLenMs : i_cfg.window_ms;
        unique case (r_phase)
            PH_STARTUP: begin
                n_btn   = 1'b0;
                n_sup   = 1'b1;
                n_phase = PH_WINDOW;
            end
            PH_HANDSHAKE: begin
                n_wd   = ~fell;
                n_tick = tick_inc;
                if (tick_inc > TickBits'(i_cfg.hs_timeout)) begin
                    n_fast  = 1'b0;
                    n_phase = PH_OFF;
                end else if (fell) begin
                    n_phase = PH_WINDOW;
                end else begin
                    n_last = i_item.watchdog_level;
                end
            end
            PH_WINDOW: begin
                if (n_btn) begin
                    n_btn   = 1'b0;
                    n_phase = PH_SETTLE;
                end else begin
                    n_tick = tick_inc;
                    if (tick_inc >= win_len) begin
                        n_phase = PH_HANDSHAKE;
                    end
                end
            end
            PH_OFF: begin
                n_sup  = 1'b0;
                n_tick = tick_inc;
                if (tick_inc >= TickBits'(i_cfg.off_hold)) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_sup = 1'b1;
                if (r_goen) begin
                    n_goen  = 1'b0;
                    n_phase = PH_SETTLE;
                end else if (v_good) begin
                    n_phase = PH_WINDOW;
                end else begin
                    n_tick = tick_inc;
                    if (v_late) begin
                        n_phase = PH_OFF;
                    end
                end
            end
            PH_SETTLE: begin
                n_tick = tick_inc;
                if (tick_inc >= TickBits'(i_cfg.settle)) begin
                    n_phase = PH_ENCHECK;
                end
            end
            PH_ENCHECK: begin
                if (v_good) begin
                    n_phase = PH_HOSTWAIT;
                end else begin
                    n_tick = tick_inc;
                    if (v_late) begin
                        n_goen  = 1'b1;
                        n_phase = PH_OFF;
                    end
                end
            end
            default: begin
                if (i_item.host_power_good) begin
                    n_phase = PH_STARTUP;
                end
            end
        endcase
        if (n_phase != r_phase) begin
            n_tick = '0;
            if (n_phase == PH_HANDSHAKE) begin
                n_last = 1'b0;
            end
        end
    end

    // result of this tick
    always_comb begin
        n_io = (r_phase == PH_HOSTWAIT) && !i_item.host_power_good;
        o_result.supply_enable  = n_sup;
        o_result.watchdog_drive = n_wd;
        o_result.io_disable     = n_io;
        o_result.phase_code     = n_phase;
        o_result.phase_changed  = n_phase != r_phase;
        o_result.fast_active    = n_fast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SETTLE;
            r_tick  <= '0;
            r_last  <= 1'b0;
            r_btn   <= 1'b0;
            r_fast  <= 1'b0;
            r_goen  <= 1'b0;
            r_sup   <= 1'b0;
            r_wd    <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_last  <= n_last;
            r_btn   <= n_btn;
            r_fast  <= n_fast;
            r_goen  <= n_goen;
            r_sup   <= n_sup;
            r_wd    <= n_wd;
        end
    end

`include "assert_macros.svh"

    `PWSUP_ASSERT(a_tick_restart, i_accept && (n_phase != r_phase) |=> r_tick == '0, "tick count not cleared on phase change")
    `PWSUP_ASSERT(a_hold_idle, !i_accept |=> $stable(r_phase) && $stable(r_tick), "state moved without a transfer")
    `PWSUP_ASSERT(a_sup_off, i_accept && (r_phase == PH_OFF) |=> !r_sup, "supply on during off hold")

endmodule

// ----- rtl/core/power_watchdog_supervisor.sv -----
// top level of the power watchdog supervisor
// results: each result is registered in a two-entry result buffer and is shown on m_axis
//   once earlier results have gone; one item per cycle is taken while the buffer is not
//   full, so items keep coming in while one result waits on m_axis_tready
// reset: synchronous active-low i_rst_n puts the phase in settle, clears
//   counters, flags and the result buffer, and loads register defaults
module power_watchdog_supervisor import pwsup_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // watchdog_level, voltage_sample, button_edge, host_power_good, fast_request
    input  logic [InBits-1:0]      s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // supply_enable, watchdog_drive, io_disable, phase_code, phase_changed, fast_active
    output logic [OutBits-1:0]     m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CfgIdxBits-1:0]  i_cfg_index,
    input  logic [CfgDataBits-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   item;
    t_result result;
    logic    in_xfer;
    logic    out_xfer;

    t_result     r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_cfg_ready = 1'b1;

    assign item.watchdog_level  = s_axis_tdata[0];
    assign item.voltage_sample  = s_axis_tdata[AdcBits:1];
    assign item.button_edge     = s_axis_tdata[AdcBits+1];
    assign item.host_power_good = s_axis_tdata[AdcBits+2];
    assign item.fast_request    = s_axis_tdata[AdcBits+3];

    assign s_axis_tready = r_count != 2'd2;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_count != 2'd0;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_slot[r_rd_ptr];

    pwsup_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    pwsup_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_xfer),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_slot[r_wr_ptr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (in_xfer) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_xfer) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (in_xfer && !out_xfer) begin
                r_count <= r_count + 2'd1;
            end else if (out_xfer && !in_xfer) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

`include "assert_macros.svh"

    `PWSUP_ASSERT(a_count_range, r_count != 2'd3, "result buffer count out of range")
    `PWSUP_ASSERT(a_count_up, in_xfer && !out_xfer |=> r_count == $past(r_count) + 2'd1, "buffer count missed a transfer")
    `PWSUP_ASSERT(a_ptr_gap, (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr), "buffer pointers out of step")

endmodule

// ----- bench/tb.sv -----
// testbench for power_watchdog_supervisor: directed and random ticks against a phase tracker
`timescale 1ns / 1ps

module tb import pwsup_pkg::*; ();

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CfgIdxBits-1:0] SPARE_INDEX_LO = 3'd6;
    localparam logic [CfgIdxBits-1:0] SPARE_INDEX_HI = 3'd7;

    typedef enum {VOLT_WAIT, VOLT_GOOD, VOLT_EXPIRED} t_volt_state;

    typedef struct {
        logic [CfgDataBits-1:0] hs_timeout;
        logic [CfgDataBits-1:0] off_hold;
        logic [CfgDataBits-1:0] settle;
        logic [CfgDataBits-1:0] v_threshold;
        logic [CfgDataBits-1:0] v_timeout;
        logic [CfgDataBits-1:0] window_sec;
    } t_settings;

    class supply_phase_tracker;
        localparam logic [TickBits-1:0] TICK_CEILING = {TickBits{1'b1}};
        localparam int MS_PER_SECOND = 1000;

        logic [MsBits-1:0]  hs_timeout, off_hold, settle, v_timeout;
        logic [AdcBits-1:0] v_thr;
        logic [SecBits-1:0] window_sec;

        t_phase            phase;
        logic [TickBits-1:0] ticks;
        logic              last_wd, button_pending, fast, enable_retry, supply, wd_out;

        t_result     expected_outputs[$];
        int          fails;
        int          checked;
        int unsigned entries[8];

        function new();
            hs_timeout     = 16'd2000;
            off_hold       = 16'd2000;
            settle         = 16'd200;
            v_thr          = 10'd450;
            v_timeout      = 16'd1000;
            window_sec     = 8'd90;
            phase          = PH_SETTLE;
            ticks          = '0;
            last_wd        = 1'b0;
            button_pending = 1'b0;
            fast           = 1'b0;
            enable_retry   = 1'b0;
            supply         = 1'b0;
            wd_out         = 1'b0;
            fails          = 0;
            checked        = 0;
            foreach (entries[i]) entries[i] = 0;
        endfunction

        task report(string msg);
            if (fails < 30) $display("MISMATCH: %s", msg);
            fails++;
        endtask

        function int pending();
            return expected_outputs.size();
        endfunction

        function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
            case (idx)
                REG_HS_TIMEOUT:  hs_timeout = data;
                REG_OFF_HOLD:    off_hold   = data;
                REG_SETTLE:      settle     = data;
                REG_V_THRESHOLD: v_thr      = data[AdcBits-1:0];
                REG_V_TIMEOUT:   v_timeout  = data;
                REG_WINDOW_SEC:  window_sec = data[SecBits-1:0];
                default: ;
            endcase
        endfunction

        function void count_tick();
            if (ticks != TICK_CEILING) ticks++;
        endfunction

        function t_volt_state test_voltage(logic [AdcBits-1:0] v);
            if (v >= v_thr) return VOLT_GOOD;
            count_tick();
            return (ticks > v_timeout) ? VOLT_EXPIRED : VOLT_WAIT;
        endfunction

        // advance one millisecond tick and queue the outputs it must produce
        function void take_tick(logic [InBits-1:0] d);
            logic               wd, btn, hp, fr, io, fell;
            logic [AdcBits-1:0] v;
            logic [TickBits-1:0] len;
            t_phase             nxt;
            t_volt_state        vs;
            t_result            r;
            wd  = d[0];
            v   = d[AdcBits:1];
            btn = d[AdcBits+1];
            hp  = d[AdcBits+2];
            fr  = d[AdcBits+3];
            nxt = phase;
            io  = 1'b0;
            if (fr) fast = 1'b1;
            if (btn) button_pending = 1'b1;
            case (phase)
                PH_STARTUP: begin
                    button_pending = 1'b0;
                    supply = 1'b1;
                    nxt = PH_WINDOW;
                end
                PH_HANDSHAKE: begin
                    fell = last_wd && !wd;
                    wd_out = !fell;
                    count_tick();
                    if (ticks > hs_timeout) begin
                        fast = 1'b0;
                        nxt = PH_OFF;
                    end else if (fell) begin
                        nxt = PH_WINDOW;
                    end else begin
                        last_wd = wd;
                    end
                end
                PH_WINDOW: begin
                    if (button_pending) begin
                        button_pending = 1'b0;
                        nxt = PH_SETTLE;
                    end else begin
                        len = fast ? TickBits'(MS_PER_SECOND)
                                   : TickBits'(window_sec * MS_PER_SECOND);
                        count_tick();
                        if (ticks >= len) nxt = PH_HANDSHAKE;
                    end
                end
                PH_OFF: begin
                    supply = 1'b0;
                    count_tick();
                    if (ticks >= off_hold) nxt = PH_CHECK;
                end
                PH_CHECK: begin
                    supply = 1'b1;
                    if (enable_retry) begin
                        enable_retry = 1'b0;
                        nxt = PH_SETTLE;
                    end else begin
                        vs = test_voltage(v);
                        if (vs == VOLT_GOOD) nxt = PH_WINDOW;
                        else if (vs == VOLT_EXPIRED) nxt = PH_OFF;
                    end
                end
                PH_SETTLE: begin
                    count_tick();
                    if (ticks >= settle) nxt = PH_ENCHECK;
                end
                PH_ENCHECK: begin
                    vs = test_voltage(v);
                    if (vs == VOLT_GOOD) begin
                        nxt = PH_HOSTWAIT;
                    end else if (vs == VOLT_EXPIRED) begin
                        enable_retry = 1'b1;
                        nxt = PH_OFF;
                    end
                end
                default: begin
                    if (hp) nxt = PH_STARTUP;
                    else io = 1'b1;
                end
            endcase
            if (nxt != phase) begin
                ticks = '0;
                if (nxt == PH_HANDSHAKE) last_wd = 1'b0;
                entries[nxt]++;
            end
            r.supply_enable  = supply;
            r.watchdog_drive = wd_out;
            r.io_disable     = io;
            r.phase_code     = nxt;
            r.phase_changed  = (nxt != phase);
            r.fast_active    = fast;
            phase = nxt;
            expected_outputs.push_back(r);
        endfunction

        task compare_field(string name, logic [2:0] got, logic [2:0] want);
            if (got !== want)
                report($sformatf("tick %0d %s: got %0d, expected %0d", checked, name, got, want));
        endtask

        task check_tick_result(t_result got);
            t_result want;
            if (expected_outputs.size() == 0) begin
                report($sformatf("result 0x%02h with no tick outstanding", got));
                return;
            end
            want = expected_outputs.pop_front();
            compare_field("supply_enable", got.supply_enable, want.supply_enable);
            compare_field("watchdog_drive", got.watchdog_drive, want.watchdog_drive);
            compare_field("io_disable", got.io_disable, want.io_disable);
            compare_field("phase_code", got.phase_code, want.phase_code);
            compare_field("phase_changed", got.phase_changed, want.phase_changed);
            compare_field("fast_active", got.fast_active, want.fast_active);
            checked++;
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [InBits-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OutBits-1:0]     m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CfgIdxBits-1:0]  i_cfg_index = '0;
    logic [CfgDataBits-1:0] i_cfg_data = '0;

    supply_phase_tracker sb;
    bit calm = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    int reg_writes = 0;

    power_watchdog_supervisor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_tick_result(t_result'(m_axis_tdata));
    end

    function automatic logic [InBits-1:0] pack_tick(logic wd, logic [AdcBits-1:0] v,
                                                    logic btn, logic hp, logic fr);
        return InBits'({fr, hp, btn, v, wd});
    endfunction

    function automatic logic [InBits-1:0] random_tick(int btn_pct, int fr_pm, int wd_pct);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 1023);
            1: v = $urandom_range(0, 1) ? 1023 : 0;
            2: v = int'(sb.v_thr) + int'($urandom_range(0, 4)) - 2;
            default: v = $urandom_range(0, 1023);
        endcase
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return pack_tick($urandom_range(0, 99) < wd_pct, AdcBits'(v),
                         $urandom_range(0, 99) < btn_pct, $urandom_range(0, 99) < 30,
                         $urandom_range(0, 999) < fr_pm);
    endfunction

    // entered and left at a falling edge
    task automatic send_tick(input logic [InBits-1:0] d);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.take_tick(d);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxBits-1:0] idx,
                             input logic [CfgDataBits-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
    endtask

    // settle the block, load a register set, then stream random ticks
    task automatic run_phase(input t_settings s, input int count, input int btn_pct,
                             input int fr_pm, input int wd_pct);
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        cfg_write(REG_HS_TIMEOUT, s.hs_timeout);
        cfg_write(REG_OFF_HOLD, s.off_hold);
        cfg_write(REG_SETTLE, s.settle);
        cfg_write(REG_V_THRESHOLD, s.v_threshold);
        cfg_write(REG_V_TIMEOUT, s.v_timeout);
        cfg_write(REG_WINDOW_SEC, s.window_sec);
        cfg_write(SPARE_INDEX_LO, CfgDataBits'($urandom));
        cfg_write(SPARE_INDEX_HI, CfgDataBits'($urandom));
        i_cfg_valid <= 1'b0;
        repeat (count) send_tick(random_tick(btn_pct, fr_pm, wd_pct));
    endtask

    initial begin
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_phase('{16'd3, 16'd2, 16'd1, 16'd512, 16'd2, 16'd0}, 0, 0, 0, 0);
        // settle into enable check, which times out and arms the retry path
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b1, 10'd511, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b1, 1'b0));
        repeat (2) send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        // check goes straight back to settle on a retry
        send_tick(pack_tick(1'b0, 10'd1023, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        // reading exactly at threshold is good
        send_tick(pack_tick(1'b0, 10'd512, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b1, 1'b0));
        // button seen in startup is dropped
        send_tick(pack_tick(1'b0, 10'd0, 1'b1, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b1, 10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b1, 10'd0, 1'b0, 1'b0, 1'b0));
        // falling edge on the timeout tick still power-cycles
        repeat (3) send_tick(pack_tick(1'b1, 10'd0, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));
        repeat (2) send_tick(pack_tick(1'b1, 10'd1023, 1'b1, 1'b1, 1'b0));
        send_tick(pack_tick(1'b0, 10'd511, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd1023, 1'b0, 1'b0, 1'b0));
        send_tick(pack_tick(1'b0, 10'd0, 1'b0, 1'b0, 1'b0));

        run_phase('{16'd5, 16'd3, 16'd2, 16'd512, 16'd4, 16'd0}, 100, 10, 0, 50);
        run_phase('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 60, 10, 0, 50);
        run_phase('{16'd1, 16'd1, 16'd3, 16'd1023, 16'd1, 16'd0}, 60, 15, 0, 60);
        run_phase('{16'($urandom_range(0, 20)), 16'($urandom_range(0, 8)),
                    16'($urandom_range(0, 8)), 16'($urandom_range(0, 1023)),
                    16'($urandom_range(0, 10)), 16'd0}, 100, 8, 15, 50);
        // long quiet stretch so a one second window runs out
        run_phase('{16'd2, 16'd1, 16'd1, 16'd300, 16'd3, 16'd1}, 1030, 0, 0, 0);
        run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                  40, 10, 10, 50);
        calm = 1'b1;
        run_phase('{16'd6, 16'd2, 16'd2, 16'($urandom), 16'd6, 16'hFF00}, 100, 10, 5, 50);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("%0d ticks checked, %0d register writes, %0d mismatches",
                 sb.checked, reg_writes, sb.fails);
        $display("phase entries startup..host wait: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.entries[0], sb.entries[1], sb.entries[2], sb.entries[3],
                 sb.entries[4], sb.entries[5], sb.entries[6], sb.entries[7]);
        if (sb.fails == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
